// ===== rtl/core/cibp_pkg.sv =====
// Shared types, constants and a helper function for the constrained integer bit packer.
`timescale 1ns / 1ps

package cibp_pkg;

	// Field widths fixed by the request format.
	localparam int VAL_W   = 64;
	localparam int DIG_W   = 8;
	localparam int NUM_DIG = VAL_W / DIG_W;
	localparam int WID_W   = 7;
	localparam int TOT_W   = 19;
	localparam int CAP_W   = 16;

	// Default parameter values and register reset values.
	localparam int              MAX_FIELD_BITS_DEF = 32;
	localparam logic [CAP_W-1:0] CAP_RESET          = 16'd64;

	// Configuration register indexes.
	localparam logic REG_CAP_BYTES = 1'b0;

	// Request actions.
	localparam logic ACT_APPEND = 1'b0;
	localparam logic ACT_FINISH = 1'b1;

	// Message status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [1:0] STAT_WIDE     = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIG,
		S_CHK,
		S_SHF,
		S_FIN
	} state_t;

	// One input request.
	typedef struct packed {
		logic                    action;
		logic signed [VAL_W-1:0] field_value;
		logic signed [VAL_W-1:0] range_low;
		logic signed [VAL_W-1:0] range_high;
	} in_req_t;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic [1:0] status;
	} out_res_t;

	// Bit length of an eight-bit digit, zero for a zero digit.
	function automatic logic [3:0] bitlen8(input logic [7:0] d);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (d[i]) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/core/constrained_int_bit_packer.sv =====
// Constrained integer bit packer: turns constrained whole numbers into an MSB-first byte stream.
// Usage: requests arrive on in_valid/in_stall/in_data; an append request (action 0) carries a
// value and its bounds, a finish request (action 1) closes the message. Result items leave on
// out_valid/out_stall/out_data, at most one byte per result; a finish gives exactly one result with
// last set and the message status. cap_bytes must be written by the user over the APB port
// only while idle; the block itself does not enforce this. Flow: an append is accepted, then
// the 64-bit operands pass an eight-bit subtractor digit by digit, then a check step runs, and
// the offset of a field that passes is shifted bit by bit into the byte assembler. A finish is
// accepted and then hands over its result. The bit-serial assembler sets the rate.
// in_stall is high whenever a request is in progress; results wait in a single output register,
// so the next request is taken while the last byte still waits. A stalled receiver halts the
// assembler only when it has a byte to hand over.
// Reset clears the message state, sets cap_bytes to 64 and empties the output register; no
// clearing pass is needed.
`timescale 1ns / 1ps

module constrained_int_bit_packer #(
	parameter int MAX_FIELD_BITS = cibp_pkg::MAX_FIELD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  cibp_pkg::in_req_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output cibp_pkg::out_res_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int OFF_DIG = (MAX_FIELD_BITS + cibp_pkg::DIG_W - 1) / cibp_pkg::DIG_W;
	localparam int OFF_W   = OFF_DIG * cibp_pkg::DIG_W;
	localparam int CNT_W   = $clog2(OFF_W);

	cibp_pkg::state_t state_q, state_nx;

	logic [cibp_pkg::CAP_W-1:0] cap_q;
	logic [cibp_pkg::VAL_W-1:0] val_sr_q, lo_sr_q, hi_sr_q;
	logic                       action_q;
	logic [2:0]                 dig_q;
	logic                       bs_q, bo_q, neg_q;
	logic [cibp_pkg::WID_W-1:0] wid_q;
	logic [OFF_W-1:0]           off_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [6:0]                 acc_q;
	logic [2:0]                 pend_q;
	logic [cibp_pkg::TOT_W-1:0] total_q;
	logic                       ok_q;
	logic [1:0]                 err_q;
	logic                       out_valid_q;
	cibp_pkg::out_res_t         out_data_q;

	logic       in_acc, out_free, load_out, shf_go, dig_last;
	logic [8:0] span9, sgn9, off9;
	logic [7:0] hi_d, lo_d, va_d;
	logic [cibp_pkg::TOT_W:0] sum_bits, lim_bits;
	logic       wide_err, cap_err, skip;
	logic [1:0] fin_stat;
	logic [3:0] pad_sh;
	logic [7:0] fin_byte;
	logic       bit_in;
	cibp_pkg::out_res_t load_data;

	// Configuration port: one register, writes complete in the access phase.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == cibp_pkg::REG_CAP_BYTES) ? {16'h0000, cap_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cibp_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == cibp_pkg::REG_CAP_BYTES) begin
			cap_q <= pwdata[cibp_pkg::CAP_W-1:0];
		end
	end

	// Digit subtractors: span and offset, least significant digit first.
	assign hi_d     = hi_sr_q[7:0];
	assign lo_d     = lo_sr_q[7:0];
	assign va_d     = val_sr_q[7:0];
	assign span9    = {1'b0, hi_d} - {1'b0, lo_d} - {8'h00, bs_q};
	assign sgn9     = {1'b0, hi_d ^ 8'h80} - {1'b0, lo_d ^ 8'h80} - {8'h00, bs_q};
	assign off9     = {1'b0, va_d} - {1'b0, lo_d} - {8'h00, bo_q};
	assign dig_last = (dig_q == 3'(cibp_pkg::NUM_DIG - 1));

	// Field checks against width limit and message capacity.
	assign sum_bits = {1'b0, total_q} + {13'h0000, wid_q};
	assign lim_bits = {1'b0, cap_q, 3'b000};
	assign skip     = !ok_q || neg_q || (wid_q == '0);
	assign wide_err = (wid_q > cibp_pkg::WID_W'(MAX_FIELD_BITS));
	assign cap_err  = (sum_bits > lim_bits);

	// Finish result: padded partial byte or status only.
	assign fin_stat = !ok_q ? err_q :
		((cap_q == '0) ? cibp_pkg::STAT_OVERFLOW : cibp_pkg::STAT_OK);
	assign pad_sh   = 4'd8 - {1'b0, pend_q};
	assign fin_byte = 8'({1'b0, acc_q} << pad_sh);

	assign bit_in   = off_q[cnt_q];
	assign out_free = !out_valid_q || !out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			cibp_pkg::S_IDLE: begin
				if (in_acc) begin
					state_nx = (in_data.action == cibp_pkg::ACT_FINISH) ?
						cibp_pkg::S_FIN : cibp_pkg::S_DIG;
				end
			end
			cibp_pkg::S_DIG: begin
				if (dig_last) begin
					state_nx = cibp_pkg::S_CHK;
				end
			end
			cibp_pkg::S_CHK: begin
				state_nx = (skip || wide_err || cap_err) ? cibp_pkg::S_IDLE : cibp_pkg::S_SHF;
			end
			cibp_pkg::S_SHF: begin
				if (shf_go && cnt_q == '0) begin
					state_nx = cibp_pkg::S_IDLE;
				end
			end
			cibp_pkg::S_FIN: begin
				if (out_free) begin
					state_nx = cibp_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = cibp_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = 1'b1;
		shf_go    = 1'b0;
		load_out  = 1'b0;
		load_data = '0;
		case (state_q)
			cibp_pkg::S_IDLE: begin
				in_stall = 1'b0;
			end
			cibp_pkg::S_SHF: begin
				shf_go = (pend_q != 3'd7) || out_free;
				if (pend_q == 3'd7 && out_free) begin
					load_out             = 1'b1;
					load_data.out_byte   = {acc_q, bit_in};
					load_data.byte_valid = 1'b1;
				end
			end
			cibp_pkg::S_FIN: begin
				if (out_free) begin
					load_out         = 1'b1;
					load_data.last   = 1'b1;
					load_data.status = fin_stat;
					if (fin_stat == cibp_pkg::STAT_OK && pend_q != '0) begin
						load_data.out_byte   = fin_byte;
						load_data.byte_valid = 1'b1;
					end
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cibp_pkg::S_IDLE;
			pend_q  <= '0;
			total_q <= '0;
			ok_q    <= 1'b1;
			err_q   <= cibp_pkg::STAT_OK;
			dig_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				cibp_pkg::S_IDLE: begin
					dig_q <= '0;
				end
				cibp_pkg::S_DIG: begin
					dig_q <= dig_q + 3'd1;
				end
				cibp_pkg::S_CHK: begin
					if (!skip) begin
						if (wide_err) begin
							ok_q  <= 1'b0;
							err_q <= cibp_pkg::STAT_WIDE;
						end else if (cap_err) begin
							ok_q  <= 1'b0;
							err_q <= cibp_pkg::STAT_OVERFLOW;
						end else begin
							total_q <= sum_bits[cibp_pkg::TOT_W-1:0];
							cnt_q   <= CNT_W'(wid_q - 7'd1);
						end
					end
				end
				cibp_pkg::S_SHF: begin
					if (shf_go) begin
						pend_q <= pend_q + 3'd1;
						cnt_q  <= cnt_q - CNT_W'(1);
					end
				end
				cibp_pkg::S_FIN: begin
					if (out_free) begin
						pend_q  <= '0;
						total_q <= '0;
						ok_q    <= 1'b1;
						err_q   <= cibp_pkg::STAT_OK;
					end
				end
				default: begin
					dig_q <= '0;
				end
			endcase
		end
	end

	// Operand shift registers, borrow chain, width tracking and offset capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= in_data.action;
			val_sr_q <= in_data.field_value;
			lo_sr_q  <= in_data.range_low;
			hi_sr_q  <= in_data.range_high;
			bs_q     <= 1'b0;
			bo_q     <= 1'b0;
			wid_q    <= '0;
			neg_q    <= 1'b0;
		end else if (state_q == cibp_pkg::S_DIG) begin
			val_sr_q <= {8'h00, val_sr_q[cibp_pkg::VAL_W-1:8]};
			lo_sr_q  <= {8'h00, lo_sr_q[cibp_pkg::VAL_W-1:8]};
			hi_sr_q  <= {8'h00, hi_sr_q[cibp_pkg::VAL_W-1:8]};
			bs_q     <= span9[8];
			bo_q     <= off9[8];
			if (span9[7:0] != 8'h00) begin
				wid_q <= {1'b0, dig_q, 3'b000} + {3'b000, cibp_pkg::bitlen8(span9[7:0])};
			end
			if (dig_last) begin
				neg_q <= sgn9[8];
			end
			if (dig_q < 3'(OFF_DIG)) begin
				off_q <= {off9[7:0], off_q[OFF_W-1:cibp_pkg::DIG_W]};
			end
		end
	end

	// Byte assembler: one offset bit per cycle but for output stalls, most significant first.
	always_ff @(posedge clk) begin
		if (state_q == cibp_pkg::S_SHF && shf_go) begin
			acc_q <= {acc_q[5:0], bit_in};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= load_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// A failed status never comes with a message byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != cibp_pkg::STAT_OK |-> !out_data.byte_valid)
		else $error("failed status result carries a byte");

	// An accepted finish request goes straight to the result stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.action == cibp_pkg::ACT_FINISH
		|=> state_q == cibp_pkg::S_FIN)
		else $error("finish request did not reach the result stage");

	// Only fields that passed the checks are shifted in.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cibp_pkg::S_SHF |-> wid_q != '0 && !wide_err && ok_q
		&& action_q == cibp_pkg::ACT_APPEND)
		else $error("bit assembler running on a rejected field");
`endif

endmodule
